// File: src/btpc_pkg.sv
// ----------------------------------------------------------------------------
// btpc_pkg
// Shared types and constants of the temperature/pressure compensation block.
// ----------------------------------------------------------------------------
package btpc_pkg;

  // Width of the pressure dividend; the divider retires one quotient bit per stage
  localparam int NumW     = 64;
  localparam int DivSteps = NumW;
  // Divisor magnitude: an arithmetic shift right by 33 of a 64-bit word leaves 31 bits
  localparam int DenW     = 31;

  // Register map, index = paddr[4:3]
  typedef enum logic [1:0] {
    REG_TEMP       = 2'd0,
    REG_PRESS_LO   = 2'd1,
    REG_PRESS_HI   = 2'd2,
    REG_PRESS_NINE = 2'd3
  } btpc_reg_t;

  // Sideband that rides along the division pipeline
  typedef struct packed {
    logic [31:0] tf;   // fine temperature
    logic [31:0] tc;   // temperature, 0.01 degC
    logic        dz;   // divisor was zero
    logic        neg;  // quotient must be negated
  } btpc_tag_t;

endpackage

// File: src/btpc_divider.sv
// ----------------------------------------------------------------------------
// btpc_divider
// Pipelined unsigned restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module btpc_divider (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_vld,
  input  logic [63:0]              in_num,
  input  logic [30:0]              in_den,
  input  btpc_pkg::btpc_tag_t      in_tag,
  output logic                     out_vld,
  output logic [63:0]              out_quo,
  output btpc_pkg::btpc_tag_t      out_tag
);
  import btpc_pkg::*;

  logic            vld_r [DivSteps];
  logic [DenW-1:0] rem_r [DivSteps];
  logic [NumW-1:0] nq_r  [DivSteps];
  logic [DenW-1:0] den_r [DivSteps];
  btpc_tag_t       tag_r [DivSteps];

  for (genvar k = 0; k < DivSteps; k++) begin : g_step
    logic            v_in;
    logic [DenW-1:0] r_in;
    logic [NumW-1:0] n_in;
    logic [DenW-1:0] d_in;
    btpc_tag_t       t_in;
    logic [DenW:0]   trial;
    logic [DenW:0]   diff;
    logic            ge;

    if (k == 0) begin : g_first
      assign v_in = in_vld;
      assign r_in = '0;
      assign n_in = in_num;
      assign d_in = in_den;
      assign t_in = in_tag;
    end else begin : g_next
      assign v_in = vld_r[k-1];
      assign r_in = rem_r[k-1];
      assign n_in = nq_r[k-1];
      assign d_in = den_r[k-1];
      assign t_in = tag_r[k-1];
    end

    // shift in the next dividend bit, subtract if it fits
    always_comb begin
      trial = {r_in, n_in[NumW-1]};
      diff  = trial - {1'b0, d_in};
      ge    = (trial >= {1'b0, d_in});
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k] <= ge ? diff[DenW-1:0] : trial[DenW-1:0];
      nq_r[k]  <= {n_in[NumW-2:0], ge};
      den_r[k] <= d_in;
      tag_r[k] <= t_in;
    end
  end

  assign out_vld = vld_r[DivSteps-1];
  assign out_quo = nq_r[DivSteps-1];
  assign out_tag = tag_r[DivSteps-1];

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld |-> $past(in_vld, DivSteps))
    else $error("divider output without matching input");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld && den_r[DivSteps-1] != '0) |-> rem_r[DivSteps-1] < den_r[DivSteps-1])
    else $error("final remainder not below divisor");

  a_first_rem: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[0] |-> rem_r[0] <= DenW'(1))
    else $error("first stage remainder wider than one bit");
`endif

endmodule

// File: src/baro_temp_pressure_compensation.sv
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation
// 64-bit integer compensation of raw barometric temperature and pressure.
// ----------------------------------------------------------------------------
// One sample pair is taken every clock (busy stays low) and its result appears
// on the out_ ports for a single cycle, marked by out_valid; the receiver must
// take it then. The pipeline is 8 datapath stages, the 64-stage bit-per-stage
// divider for the pressure quotient, and 6 finishing stages. The user must write
// calibration registers over the APB port only while no sample is in flight;
// the block itself does not enforce this.
module baro_temp_pressure_compensation (
  input  logic        clk,
  input  logic        rst_n,
  // APB configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  // samples
  input  logic        start,
  output logic        busy,
  input  logic [19:0] in_raw_temperature,
  input  logic [19:0] in_raw_pressure,
  // results
  output logic        out_valid,
  output logic signed [31:0] out_temperature_centi,
  output logic signed [31:0] out_fine_temperature,
  output logic [31:0] out_pressure_q24_8,
  output logic        out_divide_by_zero
);
  import btpc_pkg::*;

  localparam int Latency = 8 + DivSteps + 6;
  localparam logic signed [32:0] FineOffset = 33'sd128000;
  localparam logic [20:0] RawPFull = 21'd1048576;
  localparam logic [15:0] PScale = 16'd3125;
  localparam logic [31:0] TRound = 32'd128;
  localparam logic [63:0] Bias47 = 64'h0000_8000_0000_0000;

  // low 64 bits of a 64-bit word times a signed 16-bit coefficient
  function automatic logic [63:0] mul_s16(input logic [63:0] a, input logic signed [15:0] b);
    logic signed [48:0] lo;
    logic signed [47:0] hi;
    lo = $signed({1'b0, a[31:0]}) * b;
    hi = $signed(a[63:32]) * b;
    return {{15{lo[48]}}, lo} + {hi[31:0], 32'd0};
  endfunction

  function automatic logic [63:0] mul_u16(input logic [63:0] a, input logic [15:0] b);
    logic [47:0] lo;
    logic [47:0] hi;
    lo = a[31:0] * b;
    hi = a[63:32] * b;
    return {16'd0, lo} + {hi[31:0], 32'd0};
  endfunction

  // ---------------- configuration ----------------
  logic [47:0] temp_r;
  logic [63:0] plo_r;
  logic [63:0] phi_r;
  logic [15:0] p9_r;
  logic        wr_en;
  btpc_reg_t   reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = btpc_reg_t'(paddr[4:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_r <= '0;
      plo_r  <= '0;
      phi_r  <= '0;
      p9_r   <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        REG_TEMP:       temp_r <= pwdata[47:0];
        REG_PRESS_LO:   plo_r  <= pwdata;
        REG_PRESS_HI:   phi_r  <= pwdata;
        REG_PRESS_NINE: p9_r   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_TEMP:       prdata = {16'd0, temp_r};
      REG_PRESS_LO:   prdata = plo_r;
      REG_PRESS_HI:   prdata = phi_r;
      REG_PRESS_NINE: prdata = {48'd0, p9_r};
      default:        prdata = '0;
    endcase
  end

  logic [15:0]        t1, p1;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;
  assign t1 = temp_r[15:0];
  assign t2 = temp_r[31:16];
  assign t3 = temp_r[47:32];
  assign p1 = plo_r[15:0];
  assign p2 = plo_r[31:16];
  assign p3 = plo_r[47:32];
  assign p4 = plo_r[63:48];
  assign p5 = phi_r[15:0];
  assign p6 = phi_r[31:16];
  assign p7 = phi_r[47:32];
  assign p8 = phi_r[63:48];
  assign p9 = p9_r;

  assign busy = 1'b0;

  // ---------------- valid chain ----------------
  logic [7:0] s_vld_r;
  logic [5:0] f_vld_r;
  logic       div_vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_vld_r <= '0;
      f_vld_r <= '0;
    end else begin
      s_vld_r <= {s_vld_r[6:0], start & ~busy};
      f_vld_r <= {f_vld_r[4:0], div_vld};
    end
  end

  // ---------------- stage 1: temperature products ----------------
  logic signed [17:0] a_t;
  logic signed [16:0] d_t;
  logic signed [33:0] m1, dd;
  logic signed [20:0] s1_v1_r;
  logic signed [19:0] s1_sq_r;
  logic [19:0]        s1_rp_r;

  always_comb begin
    a_t = $signed({1'b0, in_raw_temperature[19:3]}) - $signed({1'b0, t1, 1'b0});
    d_t = $signed({1'b0, in_raw_temperature[19:4]}) - $signed({1'b0, t1});
    m1  = a_t * t2;
    dd  = d_t * d_t;
  end

  always_ff @(posedge clk) begin
    s1_v1_r <= m1[31:11];
    s1_sq_r <= dd[31:12];
    s1_rp_r <= in_raw_pressure;
  end

  // ---------------- stage 2: fine temperature ----------------
  logic signed [35:0] m2;
  logic [17:0]        v2;
  logic [31:0]        s2_tf_r;
  logic [19:0]        s2_rp_r;

  always_comb begin
    m2 = s1_sq_r * t3;
    v2 = m2[31:14];
  end

  always_ff @(posedge clk) begin
    s2_tf_r <= {{11{s1_v1_r[20]}}, s1_v1_r} + {{14{v2[17]}}, v2};
    s2_rp_r <= s1_rp_r;
  end

  // ---------------- stage 3: var1 square, linear terms, centi temp ----------------
  logic signed [32:0] x1;
  logic signed [65:0] xx66;
  logic signed [48:0] x1p5, x1p2;
  logic [31:0]        t5;
  logic [63:0]        s3_xx_r;
  logic signed [48:0] s3_x1p5_r, s3_x1p2_r;
  logic [31:0]        s3_tf_r, s3_tc_r;
  logic [19:0]        s3_rp_r;

  always_comb begin
    x1   = $signed({s2_tf_r[31], s2_tf_r}) - FineOffset;
    xx66 = x1 * x1;
    x1p5 = x1 * p5;
    x1p2 = x1 * p2;
    t5   = {s2_tf_r[29:0], 2'b00} + s2_tf_r + TRound;
  end

  always_ff @(posedge clk) begin
    s3_xx_r   <= xx66[63:0];
    s3_x1p5_r <= x1p5;
    s3_x1p2_r <= x1p2;
    s3_tf_r   <= s2_tf_r;
    s3_tc_r   <= {{8{t5[31]}}, t5[31:8]};
    s3_rp_r   <= s2_rp_r;
  end

  // ---------------- stage 4: square times P6 and P3 ----------------
  logic [63:0]        s4_xxp6_r, s4_xxp3_r;
  logic signed [48:0] s4_x1p5_r, s4_x1p2_r;
  logic [31:0]        s4_tf_r, s4_tc_r;
  logic [19:0]        s4_rp_r;

  always_ff @(posedge clk) begin
    s4_xxp6_r <= mul_s16(s3_xx_r, p6);
    s4_xxp3_r <= mul_s16(s3_xx_r, p3);
    s4_x1p5_r <= s3_x1p5_r;
    s4_x1p2_r <= s3_x1p2_r;
    s4_tf_r   <= s3_tf_r;
    s4_tc_r   <= s3_tc_r;
    s4_rp_r   <= s3_rp_r;
  end

  // ---------------- stage 5: var2 and offset var1 ----------------
  logic [63:0] x1p5_w, x1p2_w, p4_w, x1b;
  logic [63:0] s5_x2_r, s5_vv_r;
  logic [20:0] s5_rpf_r;
  logic [31:0] s5_tf_r, s5_tc_r;

  always_comb begin
    x1p5_w = {{15{s4_x1p5_r[48]}}, s4_x1p5_r};
    x1p2_w = {{15{s4_x1p2_r[48]}}, s4_x1p2_r};
    p4_w   = {{48{p4[15]}}, p4};
    x1b    = {{8{s4_xxp3_r[63]}}, s4_xxp3_r[63:8]} + (x1p2_w << 12);
  end

  always_ff @(posedge clk) begin
    s5_x2_r  <= s4_xxp6_r + (x1p5_w << 17) + (p4_w << 35);
    s5_vv_r  <= x1b + Bias47;
    s5_rpf_r <= RawPFull - {1'b0, s4_rp_r};
    s5_tf_r  <= s4_tf_r;
    s5_tc_r  <= s4_tc_r;
  end

  // ---------------- stage 6: divisor, dividend before scaling ----------------
  logic [63:0] prod6;
  logic [30:0] s6_den_r;
  logic [63:0] s6_e_r;
  logic [31:0] s6_tf_r, s6_tc_r;

  assign prod6 = mul_u16(s5_vv_r, p1);

  always_ff @(posedge clk) begin
    s6_den_r <= prod6[63:33];
    s6_e_r   <= {12'd0, s5_rpf_r, 31'd0} - s5_x2_r;
    s6_tf_r  <= s5_tf_r;
    s6_tc_r  <= s5_tc_r;
  end

  // ---------------- stage 7: scale dividend, divisor magnitude ----------------
  logic [63:0] s7_num_r;
  logic [30:0] s7_dmag_r;
  logic        s7_nb_r, s7_dz_r;
  logic [31:0] s7_tf_r, s7_tc_r;

  always_ff @(posedge clk) begin
    s7_num_r  <= mul_u16(s6_e_r, PScale);
    s7_dmag_r <= s6_den_r[30] ? (31'd0 - s6_den_r) : s6_den_r;
    s7_nb_r   <= s6_den_r[30];
    s7_dz_r   <= (s6_den_r == '0);
    s7_tf_r   <= s6_tf_r;
    s7_tc_r   <= s6_tc_r;
  end

  // ---------------- stage 8: dividend magnitude ----------------
  logic [63:0] s8_nmag_r;
  logic [30:0] s8_dmag_r;
  btpc_tag_t   s8_tag_r;

  always_ff @(posedge clk) begin
    s8_nmag_r <= s7_num_r[63] ? (64'd0 - s7_num_r) : s7_num_r;
    s8_dmag_r <= s7_dmag_r;
    s8_tag_r  <= '{tf: s7_tf_r, tc: s7_tc_r, dz: s7_dz_r, neg: s7_num_r[63] ^ s7_nb_r};
  end

  // ---------------- division ----------------
  logic [63:0] div_quo;
  btpc_tag_t   div_tag;

  btpc_divider u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (s_vld_r[7]),
    .in_num  (s8_nmag_r),
    .in_den  (s8_dmag_r),
    .in_tag  (s8_tag_r),
    .out_vld (div_vld),
    .out_quo (div_quo),
    .out_tag (div_tag)
  );

  // ---------------- finish 1: signed quotient ----------------
  logic [63:0] f1_p_r;
  btpc_tag_t   f1_tag_r;

  always_ff @(posedge clk) begin
    f1_p_r   <= div_tag.neg ? (64'd0 - div_quo) : div_quo;
    f1_tag_r <= div_tag;
  end

  // ---------------- finish 2: q*q partials, P8 term ----------------
  logic [31:0] ql;
  logic [30:0] qh;
  logic [62:0] pp1;
  logic [63:0] f2_pp0_r, f2_y2p_r, f2_p_r;
  logic [30:0] f2_pp1_r;
  btpc_tag_t   f2_tag_r;

  // high word of q is sign-extended; only its low 31 bits reach the product
  always_comb begin
    ql  = f1_p_r[44:13];
    qh  = {{12{f1_p_r[63]}}, f1_p_r[63:45]};
    pp1 = ql * qh;
  end

  always_ff @(posedge clk) begin
    f2_pp0_r <= ql * ql;
    f2_pp1_r <= pp1[30:0];
    f2_y2p_r <= mul_s16(f1_p_r, p8);
    f2_p_r   <= f1_p_r;
    f2_tag_r <= f1_tag_r;
  end

  // ---------------- finish 3: q*q, var2 ----------------
  logic [63:0] f3_qq_r, f3_y2_r, f3_p_r;
  btpc_tag_t   f3_tag_r;

  always_ff @(posedge clk) begin
    f3_qq_r  <= f2_pp0_r + {f2_pp1_r, 33'd0};
    f3_y2_r  <= {{19{f2_y2p_r[63]}}, f2_y2p_r[63:19]};
    f3_p_r   <= f2_p_r;
    f3_tag_r <= f2_tag_r;
  end

  // ---------------- finish 4: P9 term ----------------
  logic [63:0] f4_y1p_r, f4_y2_r, f4_p_r;
  btpc_tag_t   f4_tag_r;

  always_ff @(posedge clk) begin
    f4_y1p_r <= mul_s16(f3_qq_r, p9);
    f4_y2_r  <= f3_y2_r;
    f4_p_r   <= f3_p_r;
    f4_tag_r <= f3_tag_r;
  end

  // ---------------- finish 5: sum and offset ----------------
  logic [63:0] sum5, p7_w;
  logic [63:0] f5_r_r;
  btpc_tag_t   f5_tag_r;

  always_comb begin
    sum5 = f4_p_r + {{25{f4_y1p_r[63]}}, f4_y1p_r[63:25]} + f4_y2_r;
    p7_w = {{48{p7[15]}}, p7};
  end

  always_ff @(posedge clk) begin
    f5_r_r   <= {{8{sum5[63]}}, sum5[63:8]} + (p7_w << 4);
    f5_tag_r <= f4_tag_r;
  end

  // ---------------- finish 6: saturate, output register ----------------
  logic [31:0] pres;

  always_comb begin
    if (f5_tag_r.dz || f5_r_r[63]) begin
      pres = '0;
    end else if (f5_r_r[63:32] != '0) begin
      pres = '1;
    end else begin
      pres = f5_r_r[31:0];
    end
  end

  logic [31:0] out_tc_r, out_tf_r, out_pres_r;
  logic        out_dz_r;

  always_ff @(posedge clk) begin
    out_tc_r   <= f5_tag_r.tc;
    out_tf_r   <= f5_tag_r.tf;
    out_pres_r <= pres;
    out_dz_r   <= f5_tag_r.dz;
  end

  assign out_valid             = f_vld_r[5];
  assign out_temperature_centi = out_tc_r;
  assign out_fine_temperature  = out_tf_r;
  assign out_pressure_q24_8    = out_pres_r;
  assign out_divide_by_zero    = out_dz_r;

`ifndef SYNTHESIS
  a_out_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, Latency))
    else $error("result strobe without a sample at the pipeline latency");

  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_divide_by_zero) |-> out_pressure_q24_8 == '0)
    else $error("nonzero pressure with zero divisor");

  a_centi: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_temperature_centi[23:0] ==
      (({out_fine_temperature[29:0], 2'b00} + out_fine_temperature + TRound) >> 8))
    else $error("centi temperature does not match fine temperature");
`endif

endmodule

// File: dv/baro_temp_pressure_compensation_tb.sv
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation_tb
// Self-checking bench: programs the calibration registers over APB across
// several settings, drives directed and random raw sample pairs with random
// start gaps, and checks every result against an in-bench compensation model.
// ----------------------------------------------------------------------------
module baro_temp_pressure_compensation_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import btpc_pkg::*;

  typedef struct {
    logic signed [31:0] temp_centi;
    logic signed [31:0] fine_temp;
    logic [31:0]        press;
    logic               dz;
  } comp_result_t;

  class comp_scoreboard;
    logic [47:0] temp_coeffs;
    logic [63:0] press_lo;
    logic [63:0] press_hi;
    logic [15:0] press_nine;
    comp_result_t pending[$];
    int mismatches;

    function new();
      temp_coeffs = '0;
      press_lo = '0;
      press_hi = '0;
      press_nine = '0;
      mismatches = 0;
    endfunction

    function void set_reg(btpc_reg_t idx, logic [63:0] val);
      case (idx)
        REG_TEMP:       temp_coeffs = val[47:0];
        REG_PRESS_LO:   press_lo = val;
        REG_PRESS_HI:   press_hi = val;
        REG_PRESS_NINE: press_nine = val[15:0];
        default: ;
      endcase
    endfunction

    function comp_result_t compensate(logic [19:0] rt, logic [19:0] rp);
      comp_result_t r;
      logic signed [31:0] t1, t2, t3, a, v1, d, sq, v2, tf;
      logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic signed [63:0] x1, x2, p, q, y1, y2, num, den, mn, md, quo;
      t1 = {16'd0, temp_coeffs[15:0]};
      t2 = {{16{temp_coeffs[31]}}, temp_coeffs[31:16]};
      t3 = {{16{temp_coeffs[47]}}, temp_coeffs[47:32]};
      p1 = {48'd0, press_lo[15:0]};
      p2 = 64'(signed'(press_lo[31:16]));
      p3 = 64'(signed'(press_lo[47:32]));
      p4 = 64'(signed'(press_lo[63:48]));
      p5 = 64'(signed'(press_hi[15:0]));
      p6 = 64'(signed'(press_hi[31:16]));
      p7 = 64'(signed'(press_hi[47:32]));
      p8 = 64'(signed'(press_hi[63:48]));
      p9 = 64'(signed'(press_nine));
      a = (rt >> 3) - (t1 << 1);
      v1 = (a * t2) >>> 11;
      d = (rt >> 4) - t1;
      sq = (d * d) >>> 12;
      v2 = (sq * t3) >>> 14;
      tf = v1 + v2;
      r.fine_temp = tf;
      r.temp_centi = (tf * 5 + 128) >>> 8;
      x1 = 64'(tf) - 64'sd128000;
      x2 = x1 * x1 * p6;
      x2 = x2 + ((x1 * p5) << 17);
      x2 = x2 + (p4 << 35);
      x1 = ((x1 * x1 * p3) >>> 8) + ((x1 * p2) << 12);
      x1 = (((64'sd1 << 47) + x1) * p1) >>> 33;
      r.dz = (x1 == 0);
      r.press = '0;
      if (!r.dz) begin
        p = 64'sd1048576 - 64'(rp);
        num = ((p << 31) - x2) * 64'sd3125;
        den = x1;
        mn = num[63] ? -num : num;
        md = den[63] ? -den : den;
        quo = $unsigned(mn) / $unsigned(md);
        p = (num[63] != den[63]) ? -quo : quo;
        q = p >>> 13;
        y1 = (p9 * q * q) >>> 25;
        y2 = (p8 * p) >>> 19;
        p = ((p + y1 + y2) >>> 8) + (p7 << 4);
        if (p < 0) r.press = '0;
        else if (p > 64'sh0FFFF_FFFF) r.press = '1;
        else r.press = p[31:0];
      end
      return r;
    endfunction

    function void note_sample(logic [19:0] rt, logic [19:0] rp);
      pending.push_back(compensate(rt, rp));
    endfunction

    function void check_result(comp_result_t got);
      comp_result_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction");
        return;
      end
      want = pending.pop_front();
      if (got.temp_centi !== want.temp_centi || got.fine_temp !== want.fine_temp ||
          got.press !== want.press || got.dz !== want.dz) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp tc=%0d tf=%0d p=%h dz=%b got tc=%0d tf=%0d p=%h dz=%b",
                   want.temp_centi, want.fine_temp, want.press, want.dz,
                   got.temp_centi, got.fine_temp, got.press, got.dz);
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic psel, penable, pwrite, pready;
  logic [4:0] paddr;
  logic [63:0] pwdata, prdata;
  logic start, busy, out_valid, out_divide_by_zero;
  logic [19:0] in_raw_temperature, in_raw_pressure;
  logic signed [31:0] out_temperature_centi, out_fine_temperature;
  logic [31:0] out_pressure_q24_8;

  comp_scoreboard sb;

  baro_temp_pressure_compensation dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end

  always @(posedge clk) begin
    comp_result_t got;
    if (rst_n && out_valid) begin
      got.temp_centi = out_temperature_centi;
      got.fine_temp = out_fine_temperature;
      got.press = out_pressure_q24_8;
      got.dz = out_divide_by_zero;
      sb.check_result(got);
    end
  end

  task automatic write_reg(btpc_reg_t idx, logic [63:0] val);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 3'b000}; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    psel <= 0; penable <= 0; pwrite <= 0;
    sb.set_reg(idx, val);
  endtask

  task automatic send_sample(logic [19:0] rt, logic [19:0] rp, bit gaps);
    int wait_cycles;
    wait_cycles = gaps ? $urandom_range(0, 17) : 0;
    if (wait_cycles > 0) begin
      start <= 0;
      repeat (wait_cycles) @(posedge clk);
    end
    start <= 1;
    in_raw_temperature <= rt;
    in_raw_pressure <= rp;
    do @(posedge clk); while (busy);
    sb.note_sample(rt, rp);
  endtask

  // drain results, then allow the pipeline to empty before touching registers
  task automatic drain();
    int guard;
    start <= 0;
    guard = 0;
    while (sb.pending.size() != 0 && guard < 10000) begin
      @(posedge clk);
      guard++;
    end
    repeat (100) @(posedge clk);
  endtask

  // typical sensor-like calibration
  task automatic load_typical();
    write_reg(REG_TEMP, {16'hFC18, 16'd26435, 16'd27504});
    write_reg(REG_PRESS_LO, {16'd2855, 16'd8192 - 16'd4, 16'hD4BD, 16'd36477});
    write_reg(REG_PRESS_HI, {16'hF9C3, 16'hFFF9, 16'd15500, 16'd140});
    write_reg(REG_PRESS_NINE, 64'd6000);
  endtask

  task automatic load_random();
    write_reg(REG_TEMP, {$urandom, $urandom});
    write_reg(REG_PRESS_LO, {$urandom, $urandom});
    write_reg(REG_PRESS_HI, {$urandom, $urandom});
    write_reg(REG_PRESS_NINE, {48'd0, 16'($urandom)});
  endtask

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) == 0)
        send_sample(20'($urandom), 20'($urandom), i % 40 >= 10);
      else
        send_sample(20'($urandom_range(400000, 600000)),
                    20'($urandom_range(200000, 450000)), i % 40 >= 10);
    end
  endtask

  initial begin
    sb = new();
    rst_n = 0; psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    start = 0; in_raw_temperature = '0; in_raw_pressure = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // all-zero calibration: divisor is zero
    send_sample(20'd0, 20'd0, 0);
    send_sample(20'hFFFFF, 20'hFFFFF, 0);
    drain();

    load_typical();
    send_sample(20'd519888, 20'd415148, 0);
    send_sample(20'd0, 20'd0, 0);
    send_sample(20'hFFFFF, 20'hFFFFF, 0);
    send_sample(20'd0, 20'hFFFFF, 0);
    send_sample(20'hFFFFF, 20'd0, 1);
    send_sample(20'h55555, 20'hAAAAA, 1);
    send_sample(20'hAAAAA, 20'h55555, 0);
    drain();

    // extremes: all-ones, then most negative signed coefficients but P6 most positive
    write_reg(REG_TEMP, '1);
    write_reg(REG_PRESS_LO, '1);
    write_reg(REG_PRESS_HI, '1);
    write_reg(REG_PRESS_NINE, '1);
    send_sample(20'd0, 20'd0, 0);
    send_sample(20'hFFFFF, 20'hFFFFF, 0);
    send_sample(20'd123456, 20'd654321, 0);
    drain();
    write_reg(REG_TEMP, {16'h8000, 16'h8000, 16'hFFFF});
    write_reg(REG_PRESS_LO, {16'h8000, 16'h8000, 16'h8000, 16'hFFFF});
    write_reg(REG_PRESS_HI, {16'h8000, 16'h8000, 16'h7FFF, 16'h8000});
    write_reg(REG_PRESS_NINE, 64'h8000);
    send_sample(20'd0, 20'd0, 0);
    send_sample(20'hFFFFF, 20'hFFFFF, 0);
    send_sample(20'd80000, 20'd1, 0);
    drain();
    write_reg(REG_PRESS_HI, {16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF});
    write_reg(REG_PRESS_NINE, 64'h7FFF);
    send_sample(20'd500000, 20'd300000, 0);
    send_sample(20'd1, 20'hFFFFF, 0);
    drain();

    load_typical();
    random_phase(250);
    drain();
    for (int k = 0; k < 5; k++) begin
      load_random();
      random_phase(50);
      drain();
    end

    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end
endmodule
